[hw/rtl/ble_adv_sensor_payload_parser_macros.svh]
// Assertion helpers shared by the parser RTL.
`ifndef BLE_ADV_SENSOR_PAYLOAD_PARSER_MACROS_SVH
`define BLE_ADV_SENSOR_PAYLOAD_PARSER_MACROS_SVH

// Same-cycle implication, off while reset is held.
`define BLEADV_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, off while reset is held.
`define BLEADV_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/bleadv_pkg.sv]
`default_nettype none

package bleadv_pkg;

    localparam int POS_W      = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_COMPANY_CODE        = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MFG_TYPE_CODE       = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COUNTER_PAYLOAD_LEN = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CLIMATE_PAYLOAD_LEN = 2'd3;

    // profile codes
    localparam logic [1:0] PROF_NONE    = 2'd0;
    localparam logic [1:0] PROF_CLIMATE = 2'd1;
    localparam logic [1:0] PROF_COUNTER = 2'd2;

    localparam logic [15:0] COMPANY_CODE_RST = 16'hFFFF;
    localparam logic [7:0]  MFG_TYPE_RST     = 8'hFF;
    localparam logic [7:0]  COUNTER_LEN_RST  = 8'd6;
    localparam logic [7:0]  CLIMATE_LEN_RST  = 8'd10;

    typedef struct packed {
        logic [7:0]         adv_byte;
        logic               last_byte;
        logic signed [7:0]  signal_strength;
        logic [47:0]        device_address;
        logic [31:0]        timestamp_ms;
    } in_word_t;

    typedef struct packed {
        logic [1:0]         profile;
        logic [15:0]        node_id;
        logic signed [15:0] temperature;
        logic [7:0]         humidity;
        logic [7:0]         battery_level;
        logic [15:0]        sequence_res;
        logic [31:0]        event_count;
        logic signed [7:0]  rssi_out;
        logic [47:0]        address_out;
        logic [15:0]        company_out;
        logic [31:0]        time_out;
    } out_word_t;

    typedef struct packed {
        logic [15:0] company_code;
        logic [7:0]  mfg_type_code;
        logic [7:0]  counter_payload_len;
        logic [7:0]  climate_payload_len;
    } cfg_t;

    // match state carried per packet
    typedef struct packed {
        logic [1:0]         profile;
        logic [15:0]        node_id;
        logic signed [15:0] temperature;
        logic [7:0]         humidity;
        logic [7:0]         battery_level;
        logic [15:0]        sequence_res;
        logic [31:0]        event_count;
        logic [15:0]        company;
    } match_t;

endpackage

`default_nettype wire

[hw/rtl/ble_adv_sensor_payload_parser.sv]
// Advertising-packet sensor parser. Feed one packet byte per word on the s_ channel,
// marking the final byte with last_byte; signal strength, sender address and timestamp
// are sampled with that final word. The block walks the length-type-value segments as
// bytes arrive and latches the first manufacturer segment whose company code matches and
// whose payload length fits the counter profile (exact length) or the climate profile
// (minimum length); the counter profile wins when both fit. A zero length byte stops the
// walk, a segment cut off by the packet end never matches, and bytes past MAX_ADV_BYTES
// are ignored (their last_byte mark still counts). Exactly one record leaves on the m_
// channel per packet, all zeros when nothing matched. Throughput is one byte per clock
// except while a last byte waits: a word waits in an input register while short segment
// logic feeds the result register, which loads a record as its last byte is consumed, later
// only while the previous record still waits. Only the last byte of a packet waits for
// the result register to drain; other bytes flow on while a record is held.
// Configuration registers are written through cfg_wr_en / cfg_index / cfg_wdata and
// should only change while no packet is in flight.
`default_nettype none

module ble_adv_sensor_payload_parser #(
    parameter int MAX_ADV_BYTES = 255,
    parameter int CAPTURE_BYTES = 10
) (
    input  wire logic                                   aclk,
    input  wire logic                                   aresetn,

    input  wire logic                                   s_valid,
    output logic                                        s_ready,
    input  wire bleadv_pkg::in_word_t                   s_data,

    output logic                                        m_valid,
    input  wire logic                                   m_ready,
    output bleadv_pkg::out_word_t                       m_data,

    input  wire logic                                   cfg_wr_en,
    input  wire logic [bleadv_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire logic [bleadv_pkg::CFG_DATA_W-1:0]      cfg_wdata
);

    // configuration registers
    bleadv_pkg::cfg_t cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.company_code        <= bleadv_pkg::COMPANY_CODE_RST;
            cfg_reg.mfg_type_code       <= bleadv_pkg::MFG_TYPE_RST;
            cfg_reg.counter_payload_len <= bleadv_pkg::COUNTER_LEN_RST;
            cfg_reg.climate_payload_len <= bleadv_pkg::CLIMATE_LEN_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                bleadv_pkg::REG_COMPANY_CODE: begin
                    cfg_reg.company_code <= cfg_wdata;
                end
                bleadv_pkg::REG_MFG_TYPE_CODE: begin
                    cfg_reg.mfg_type_code <= cfg_wdata[7:0];
                end
                bleadv_pkg::REG_COUNTER_PAYLOAD_LEN: begin
                    cfg_reg.counter_payload_len <= cfg_wdata[7:0];
                end
                bleadv_pkg::REG_CLIMATE_PAYLOAD_LEN: begin
                    cfg_reg.climate_payload_len <= cfg_wdata[7:0];
                end
                default: begin
                end
            endcase
        end
    end

    // input register
    logic                   in_valid_reg;
    bleadv_pkg::in_word_t   in_data_reg;
    logic                   out_free;
    logic                   advance;
    bleadv_pkg::match_t     match_next;

    // a last byte must find the result register free; plain bytes never wait
    assign advance = in_valid_reg && (!in_data_reg.last_byte || out_free);
    assign s_ready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_data_reg <= s_data;
        end
    end

    // segment walk and match state
    bleadv_walker #(
        .MAX_ADV_BYTES (MAX_ADV_BYTES),
        .CAPTURE_BYTES (CAPTURE_BYTES)
    ) u_walker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg_reg),
        .step       (advance),
        .last       (in_data_reg.last_byte),
        .adv_byte   (in_data_reg.adv_byte),
        .match_next (match_next)
    );

    // result register
    bleadv_out_stage u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (advance && in_data_reg.last_byte),
        .match_in (match_next),
        .word_in  (in_data_reg),
        .out_free (out_free),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

endmodule

`default_nettype wire

[hw/rtl/bleadv_walker.sv]
`default_nettype none
`include "ble_adv_sensor_payload_parser_macros.svh"

module bleadv_walker #(
    parameter int MAX_ADV_BYTES = 255,
    parameter int CAPTURE_BYTES = 10
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire bleadv_pkg::cfg_t  cfg,
    input  wire logic              step,
    input  wire logic              last,
    input  wire logic [7:0]        adv_byte,
    output bleadv_pkg::match_t     match_next
);

    localparam int POS_W = bleadv_pkg::POS_W;

    logic [POS_W-1:0]     pos_reg, pos_next;
    logic [7:0]           rem_reg, rem_next;
    logic [7:0]           len_reg, len_next;
    logic [7:0]           type_reg, type_next;
    logic [7:0]           cap_reg [CAPTURE_BYTES];
    logic [7:0]           cap_next [CAPTURE_BYTES];
    logic                 stopped_reg, stopped_next;
    bleadv_pkg::match_t   match_reg;

    logic [7:0]  k;
    logic [7:0]  k_m1;
    logic        seg_done;
    logic [7:0]  pay_len;
    logic [15:0] comp;

    always_comb begin
        pos_next     = pos_reg;
        rem_next     = rem_reg;
        len_next     = len_reg;
        type_next    = type_reg;
        stopped_next = stopped_reg;
        match_next   = match_reg;
        cap_next     = cap_reg;
        k            = len_reg - rem_reg;
        k_m1         = k - 8'd1;
        seg_done     = 1'b0;

        if (pos_reg < POS_W'(MAX_ADV_BYTES)) begin
            pos_next = pos_reg + POS_W'(1);
            if (!stopped_reg) begin
                if (rem_reg == 8'd0) begin
                    // length byte: zero ends the walk
                    if (adv_byte == 8'd0) begin
                        stopped_next = 1'b1;
                    end else begin
                        len_next = adv_byte;
                        rem_next = adv_byte;
                        for (int i = 0; i < CAPTURE_BYTES; i++) begin
                            cap_next[i] = 8'd0;
                        end
                    end
                end else begin
                    if (k == 8'd0) begin
                        type_next = adv_byte;
                    end else begin
                        for (int i = 0; i < CAPTURE_BYTES; i++) begin
                            if (k_m1 == 8'(i)) begin
                                cap_next[i] = adv_byte;
                            end
                        end
                    end
                    rem_next = rem_reg - 8'd1;
                    seg_done = (rem_next == 8'd0);
                end
            end
        end

        pay_len = len_reg - 8'd1;
        comp    = {cap_next[1], cap_next[0]};

        if (seg_done && type_next == cfg.mfg_type_code && comp == cfg.company_code) begin
            if (pay_len == cfg.counter_payload_len) begin
                match_next               = '0;
                match_next.profile       = bleadv_pkg::PROF_COUNTER;
                match_next.event_count   = {cap_next[5], cap_next[4], cap_next[3], cap_next[2]};
                match_next.sequence_res  = {cap_next[3], cap_next[2]};
                match_next.company       = comp;
                stopped_next             = 1'b1;
            end else if (pay_len >= cfg.climate_payload_len) begin
                match_next               = '0;
                match_next.profile       = bleadv_pkg::PROF_CLIMATE;
                match_next.node_id       = {cap_next[3], cap_next[2]};
                match_next.temperature   = {cap_next[5], cap_next[4]};
                match_next.humidity      = cap_next[6];
                match_next.battery_level = cap_next[7];
                match_next.sequence_res  = {cap_next[9], cap_next[8]};
                match_next.company       = comp;
                stopped_next             = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg     <= '0;
            rem_reg     <= '0;
            len_reg     <= '0;
            type_reg    <= '0;
            stopped_reg <= 1'b0;
            match_reg   <= '0;
        end else if (step) begin
            if (last) begin
                pos_reg     <= '0;
                rem_reg     <= '0;
                len_reg     <= '0;
                type_reg    <= '0;
                stopped_reg <= 1'b0;
                match_reg   <= '0;
            end else begin
                pos_reg     <= pos_next;
                rem_reg     <= rem_next;
                len_reg     <= len_next;
                type_reg    <= type_next;
                stopped_reg <= stopped_next;
                match_reg   <= match_next;
            end
        end
    end

    // capture bytes: zeroed at each packet end, no reset needed
    always_ff @(posedge aclk) begin
        if (step) begin
            for (int i = 0; i < CAPTURE_BYTES; i++) begin
                cap_reg[i] <= last ? 8'd0 : cap_next[i];
            end
        end
    end

    `BLEADV_ASSERT_NOW(a_pos_bounded, aclk, aresetn, 1'b1, pos_reg <= POS_W'(MAX_ADV_BYTES), "byte position ran past the packet limit")
    `BLEADV_ASSERT_NOW(a_match_stops, aclk, aresetn, match_reg.profile != bleadv_pkg::PROF_NONE, stopped_reg, "match held while walk still running")
    `BLEADV_ASSERT_NEXT(a_clear_on_last, aclk, aresetn, step && last, pos_reg == '0 && match_reg.profile == bleadv_pkg::PROF_NONE && !stopped_reg, "packet state not cleared after last byte")

endmodule

`default_nettype wire

[hw/rtl/bleadv_out_stage.sv]
`default_nettype none
`include "ble_adv_sensor_payload_parser_macros.svh"

module bleadv_out_stage (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  load,
    input  wire bleadv_pkg::match_t    match_in,
    input  wire bleadv_pkg::in_word_t  word_in,
    output logic                       out_free,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output bleadv_pkg::out_word_t      m_data
);

    logic                    valid_reg;
    bleadv_pkg::out_word_t   data_reg;
    bleadv_pkg::out_word_t   data_next;
    logic                    hit;

    always_comb begin
        hit                     = (match_in.profile != bleadv_pkg::PROF_NONE);
        data_next.profile       = match_in.profile;
        data_next.node_id       = match_in.node_id;
        data_next.temperature   = match_in.temperature;
        data_next.humidity      = match_in.humidity;
        data_next.battery_level = match_in.battery_level;
        data_next.sequence_res  = match_in.sequence_res;
        data_next.event_count   = match_in.event_count;
        data_next.company_out   = match_in.company;
        // sampled side fields only go out with a match
        data_next.rssi_out      = hit ? word_in.signal_strength : 8'sd0;
        data_next.address_out   = hit ? word_in.device_address : 48'd0;
        data_next.time_out      = hit ? word_in.timestamp_ms : 32'd0;
    end

    assign out_free = !valid_reg || m_ready;
    assign m_valid  = valid_reg;
    assign m_data   = data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (load) begin
            valid_reg <= 1'b1;
        end else if (m_ready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg <= data_next;
        end
    end

    `BLEADV_ASSERT_NEXT(a_load_shows, aclk, aresetn, load, valid_reg, "loaded record not presented")
    `BLEADV_ASSERT_NOW(a_nomatch_zero, aclk, aresetn, valid_reg && data_reg.profile == bleadv_pkg::PROF_NONE, data_reg.address_out == 48'd0 && data_reg.time_out == 32'd0 && data_reg.company_out == 16'd0, "no-match record carries data")

endmodule

`default_nettype wire
